>>> rtl/blocked_tile_address_generator_macros.svh
// Assertion macros shared by the tile address generator modules.
`ifndef BLOCKED_TILE_ADDRESS_GENERATOR_MACROS_SVH
`define BLOCKED_TILE_ADDRESS_GENERATOR_MACROS_SVH

// Same-cycle implication under synchronous reset.
`define BTAG_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("btag assertion failed");

// Next-cycle implication under synchronous reset.
`define BTAG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("btag assertion failed");

`endif

>>> rtl/btag_pkg.sv
// Types and constants of the blocked tile address generator.
package btag_pkg;

  localparam int unsigned TILE_BYTES  = 2048;
  localparam int unsigned ALIGN_BYTES = 64;
  localparam int unsigned COL_STRIDE  = 1;
  localparam int unsigned PAD_COLS    = 0;
  localparam int unsigned PAD_ROWS    = 0;

  localparam int unsigned SLOT_BYTES_INT =
    ((TILE_BYTES + ALIGN_BYTES - 1) / ALIGN_BYTES) * ALIGN_BYTES;
  localparam logic [23:0] SLOT_BYTES  = 24'(SLOT_BYTES_INT);
  localparam logic [31:0] COL_STEP    = 32'(COL_STRIDE);
  localparam logic        PAD_COL_EN  = (PAD_COLS > 0);
  localparam logic        PAD_ROW_EN  = (PAD_ROWS > 0);

  localparam int unsigned QUEUE_DEPTH = 2;

  typedef enum logic {
    OP_START = 1'b0,
    OP_STEP  = 1'b1
  } op_t;

  typedef enum logic [2:0] {
    REG_ROW_STRIDE      = 3'd0,
    REG_K_BLOCK_STRIDE  = 3'd1,
    REG_BLOCK_COLS      = 3'd2,
    REG_BLOCK_ROWS      = 3'd3,
    REG_K_BLOCK_COUNT   = 3'd4,
    REG_M_BLOCKS        = 3'd5,
    REG_M_BLOCK_STRIDE  = 3'd6,
    REG_NEXT_BATCH_JUMP = 3'd7
  } cfg_reg_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  index;
    logic [31:0] data;
  } cfg_write_t;

  typedef struct packed {
    op_t         op;
    logic [31:0] start_tile;
    logic [15:0] batches;
    logic [15:0] first_m;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } queue_head_t;

endpackage

>>> rtl/btag_front.sv
// Front end: accepts items, classifies the command and queues them.
`include "blocked_tile_address_generator_macros.svh"
module btag_front #(
  parameter int unsigned DEPTH = btag_pkg::QUEUE_DEPTH
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 command,
  input  logic [31:0]          start_tile,
  input  logic [15:0]          output_block_count,
  input  logic [15:0]          first_m_block,
  output btag_pkg::queue_head_t head,
  input  logic                 pop
);
  import btag_pkg::*;

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
  localparam logic [CW-1:0] FULL     = CW'(DEPTH);

  entry_t          slots [DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [CW-1:0]   count;
  logic            push;
  entry_t          incoming;

  assign in_stall = (count == FULL);
  assign push     = in_valid && !in_stall;

  always_comb begin
    incoming.op         = command ? OP_STEP : OP_START;
    incoming.start_tile = start_tile;
    incoming.batches    = output_block_count;
    incoming.first_m    = first_m_block;
  end

  assign head.valid = (count != '0);
  assign head.entry = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_PTR) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_PTR) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  `BTAG_ASSERT_IMPL(a_pop_nonempty, clk, rst, pop, count != '0)
  `BTAG_ASSERT_IMPL(a_count_bound, clk, rst, 1'b1, count <= FULL)
  `BTAG_ASSERT_NEXT(a_push_grows, clk, rst, push && !pop, count == $past(count) + 1'b1)

endmodule

>>> rtl/btag_back.sv
// Back end: loop sequencer, configuration registers and result register.
`include "blocked_tile_address_generator_macros.svh"
module btag_back (
  input  logic                  clk,
  input  logic                  rst,
  input  btag_pkg::cfg_write_t  cfg,
  input  btag_pkg::queue_head_t head,
  output logic                  pop,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  valid_res,
  output logic [31:0]           tile_id,
  output logic [23:0]           buffer_offset,
  output logic                  pad_columns,
  output logic                  pad_rows,
  output logic                  block_end,
  output logic                  job_end
);
  import btag_pkg::*;

  logic [31:0] row_stride;
  logic [31:0] k_block_stride;
  logic [6:0]  block_cols;
  logic [6:0]  block_rows;
  logic [15:0] k_block_count;
  logic [15:0] m_block_limit;
  logic [31:0] m_block_stride;
  logic [31:0] next_batch_jump;

  logic        active,           active_next;
  logic [15:0] batches_left,     batches_left_next;
  logic [15:0] m_block_index,    m_block_index_next;
  logic [15:0] k_block_index,    k_block_index_next;
  logic [5:0]  row_index,        row_index_next;
  logic [5:0]  col_index,        col_index_next;
  logic [31:0] batch_start_tile, batch_start_tile_next;
  logic [31:0] block_start_tile, block_start_tile_next;
  logic [31:0] row_start_tile,   row_start_tile_next;
  logic [31:0] current_tile,     current_tile_next;
  logic [23:0] slot_offset,      slot_offset_next;

  logic [5:0]  cols_m1;
  logic [5:0]  rows_m1;
  logic [15:0] kcnt_m1;
  logic        last_col, last_row, last_k, last_batch;
  logic [31:0] row_adv, blk_adv, batch_adv;
  logic [15:0] m_inc, batches_dec;
  logic        m_wrap;

  logic        res_valid;
  logic [31:0] res_tile;
  logic [23:0] res_offset;
  logic        res_pad_c, res_pad_r, res_block_end, res_job_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      row_stride     <= 32'd1;
      k_block_stride <= 32'd1;
      block_cols     <= 7'd1;
      block_rows     <= 7'd1;
      k_block_count  <= 16'd1;
      m_block_limit  <= 16'd1;
      m_block_stride <= '0;
      next_batch_jump <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_ROW_STRIDE:      row_stride      <= cfg.data;
        REG_K_BLOCK_STRIDE:  k_block_stride  <= cfg.data;
        REG_BLOCK_COLS:      block_cols      <= cfg.data[6:0];
        REG_BLOCK_ROWS:      block_rows      <= cfg.data[6:0];
        REG_K_BLOCK_COUNT:   k_block_count   <= cfg.data[15:0];
        REG_M_BLOCKS:        m_block_limit   <= cfg.data[15:0];
        REG_M_BLOCK_STRIDE:  m_block_stride  <= cfg.data;
        REG_NEXT_BATCH_JUMP: next_batch_jump <= cfg.data;
        default: ;
      endcase
    end
  end

  assign cols_m1 = (block_cols == 7'd0) ? 6'd0 :
                   (block_cols > 7'd64) ? 6'd63 : 6'(block_cols - 7'd1);
  assign rows_m1 = (block_rows == 7'd0) ? 6'd0 :
                   (block_rows > 7'd64) ? 6'd63 : 6'(block_rows - 7'd1);
  assign kcnt_m1 = (k_block_count == 16'd0) ? 16'd0 : k_block_count - 16'd1;

  assign last_col   = (col_index >= cols_m1);
  assign last_row   = (row_index >= rows_m1);
  assign last_k     = (k_block_index >= kcnt_m1);
  assign last_batch = (batches_left <= 16'd1);

  assign row_adv     = row_start_tile + row_stride;
  assign blk_adv     = block_start_tile + k_block_stride;
  assign m_inc       = m_block_index + 16'd1;
  assign m_wrap      = (m_inc == m_block_limit);
  assign batch_adv   = batch_start_tile + (m_wrap ? next_batch_jump : m_block_stride);
  assign batches_dec = batches_left - 16'd1;

  assign pop = head.valid && (!out_valid || !out_stall);

  always_comb begin
    active_next           = active;
    batches_left_next     = batches_left;
    m_block_index_next    = m_block_index;
    k_block_index_next    = k_block_index;
    row_index_next        = row_index;
    col_index_next        = col_index;
    batch_start_tile_next = batch_start_tile;
    block_start_tile_next = block_start_tile;
    row_start_tile_next   = row_start_tile;
    current_tile_next     = current_tile;
    slot_offset_next      = slot_offset;
    res_valid     = 1'b0;
    res_tile      = '0;
    res_offset    = '0;
    res_pad_c     = 1'b0;
    res_pad_r     = 1'b0;
    res_block_end = 1'b0;
    res_job_end   = 1'b0;
    if (head.entry.op == OP_START) begin
      batch_start_tile_next = head.entry.start_tile;
      block_start_tile_next = head.entry.start_tile;
      row_start_tile_next   = head.entry.start_tile;
      current_tile_next     = head.entry.start_tile;
      batches_left_next     = head.entry.batches;
      m_block_index_next    = head.entry.first_m;
      k_block_index_next    = '0;
      row_index_next        = '0;
      col_index_next        = '0;
      slot_offset_next      = '0;
      active_next           = (head.entry.batches != 16'd0);
    end else if (active) begin
      res_valid     = 1'b1;
      res_tile      = current_tile;
      res_offset    = slot_offset;
      res_pad_c     = PAD_COL_EN && last_k && last_col;
      res_pad_r     = PAD_ROW_EN && last_k && last_col;
      res_block_end = last_row && last_col;
      res_job_end   = last_row && last_col && last_k && last_batch;
      slot_offset_next  = slot_offset + SLOT_BYTES;
      current_tile_next = current_tile + COL_STEP;
      if (!last_col) begin
        col_index_next = col_index + 6'd1;
      end else begin
        col_index_next      = '0;
        row_start_tile_next = row_adv;
        current_tile_next   = row_adv;
        if (!last_row) begin
          row_index_next = row_index + 6'd1;
        end else begin
          row_index_next        = '0;
          slot_offset_next      = '0;
          block_start_tile_next = blk_adv;
          row_start_tile_next   = blk_adv;
          current_tile_next     = blk_adv;
          if (!last_k) begin
            k_block_index_next = k_block_index + 16'd1;
          end else begin
            k_block_index_next    = '0;
            m_block_index_next    = m_wrap ? 16'd0 : m_inc;
            batch_start_tile_next = batch_adv;
            block_start_tile_next = batch_adv;
            row_start_tile_next   = batch_adv;
            current_tile_next     = batch_adv;
            batches_left_next     = batches_dec;
            if (batches_dec == 16'd0) begin
              active_next = 1'b0;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      active           <= 1'b0;
      batches_left     <= '0;
      m_block_index    <= '0;
      k_block_index    <= '0;
      row_index        <= '0;
      col_index        <= '0;
      batch_start_tile <= '0;
      block_start_tile <= '0;
      row_start_tile   <= '0;
      current_tile     <= '0;
      slot_offset      <= '0;
    end else if (pop) begin
      active           <= active_next;
      batches_left     <= batches_left_next;
      m_block_index    <= m_block_index_next;
      k_block_index    <= k_block_index_next;
      row_index        <= row_index_next;
      col_index        <= col_index_next;
      batch_start_tile <= batch_start_tile_next;
      block_start_tile <= block_start_tile_next;
      row_start_tile   <= row_start_tile_next;
      current_tile     <= current_tile_next;
      slot_offset      <= slot_offset_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      valid_res     <= res_valid;
      tile_id       <= res_tile;
      buffer_offset <= res_offset;
      pad_columns   <= res_pad_c;
      pad_rows      <= res_pad_r;
      block_end     <= res_block_end;
      job_end       <= res_job_end;
    end
  end

  `BTAG_ASSERT_IMPL(a_job_end_idle, clk, rst, out_valid && valid_res && job_end, !active)
  `BTAG_ASSERT_NEXT(a_empty_start, clk, rst, pop && head.entry.op == OP_START && head.entry.batches == 16'd0, !active)
  `BTAG_ASSERT_NEXT(a_idle_step, clk, rst, pop && head.entry.op == OP_STEP && !active, out_valid && !valid_res)

endmodule

>>> rtl/blocked_tile_address_generator.sv
// Blocked tile address generator: each command gives one result; one item per cycle
// while not stalled. A front queue takes commands; the back sequencer updates its
// batch, K block, row and column counters for each command and loads the result
// register, so one item enters and one result leaves every cycle while the
// output is not stalled. A command is first written into the queue and, once
// popped, loads the result register. A stalled result holds the sequencer; the
// two-entry queue then fills and in_stall rises. A start command resets the
// counters and yields an all-zero result. Configuration writes are always taken
// and must only happen while idle.
module blocked_tile_address_generator #(
  parameter int unsigned QUEUE_DEPTH = btag_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        command,
  input  logic [31:0] start_tile,
  input  logic [15:0] output_block_count,
  input  logic [15:0] first_m_block,
  output logic        out_valid,
  input  logic        out_stall,
  output logic        valid_res,
  output logic [31:0] tile_id,
  output logic [23:0] buffer_offset,
  output logic        pad_columns,
  output logic        pad_rows,
  output logic        block_end,
  output logic        job_end,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import btag_pkg::*;

  queue_head_t head;
  logic        pop;
  cfg_write_t  cfg;

  assign cfg_ready = 1'b1;
  assign cfg.valid = cfg_valid && cfg_ready;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  btag_front #(
    .DEPTH(QUEUE_DEPTH)
  ) u_front (
    .clk                (clk),
    .rst                (rst),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .command            (command),
    .start_tile         (start_tile),
    .output_block_count (output_block_count),
    .first_m_block      (first_m_block),
    .head               (head),
    .pop                (pop)
  );

  btag_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cfg           (cfg),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .valid_res     (valid_res),
    .tile_id       (tile_id),
    .buffer_offset (buffer_offset),
    .pad_columns   (pad_columns),
    .pad_rows      (pad_rows),
    .block_end     (block_end),
    .job_end       (job_end)
  );

endmodule

>>> tb/tb.sv
// Testbench for the blocked tile address generator: directed table, then random jobs vs predictor.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import btag_pkg::*;

  localparam int unsigned CYCLE_LIMIT  = 600000;
  localparam int unsigned TARGET_ITEMS = 1400;
  localparam longint      JOB_CAP      = 160;
  localparam int unsigned DRAIN_CYCLES = 8;

  typedef struct packed {
    logic        valid_res;
    logic [31:0] tile_id;
    logic [23:0] buffer_offset;
    logic        pad_columns;
    logic        pad_rows;
    logic        block_end;
    logic        job_end;
  } tile_addr_t;

  typedef struct packed {
    entry_t     cmd;
    logic       typed_in;
    tile_addr_t want;
  } tile_req_t;

  typedef enum int unsigned {
    PH_WIDE,
    PH_SATURATED,
    PH_TALL_DEEP,
    PH_ROWS_CLAMP,
    PH_RANDOM
  } phase_t;

  typedef enum int unsigned {
    ST_FLOW,
    ST_LIGHT,
    ST_HEAVY,
    ST_PERIODIC
  } stall_mode_t;

  localparam tile_addr_t NO_ADDR = '0;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        command = OP_STEP;
  logic [31:0] start_tile = '0;
  logic [15:0] output_block_count = '0;
  logic [15:0] first_m_block = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic        valid_res;
  logic [31:0] tile_id;
  logic [23:0] buffer_offset;
  logic        pad_columns;
  logic        pad_rows;
  logic        block_end;
  logic        job_end;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = REG_ROW_STRIDE;
  logic [31:0] cfg_data = '0;

  blocked_tile_address_generator uut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // predictor copy of registers and walk state
  logic [31:0] row_step = 32'd1;
  logic [31:0] kblk_step = 32'd1;
  logic [6:0]  cols_reg = 7'd1;
  logic [6:0]  rows_reg = 7'd1;
  logic [15:0] kblk_total = 16'd1;
  logic [15:0] m_per_batch = 16'd1;
  logic [31:0] m_step = '0;
  logic [31:0] batch_jump = '0;

  logic        walk_active = 1'b0;
  logic [15:0] batches_rem = '0;
  logic [15:0] m_idx = '0;
  logic [15:0] k_idx = '0;
  logic [5:0]  row_idx = '0;
  logic [5:0]  col_idx = '0;
  logic [31:0] batch_base = '0;
  logic [31:0] block_base = '0;
  logic [31:0] row_base = '0;
  logic [31:0] tile_cur = '0;
  logic [23:0] slot_off = '0;

  tile_req_t   send_list[$];
  tile_addr_t  tile_addrs_due[$];
  logic [31:0] reg_plan [8];
  int unsigned burst_left = 0;
  int unsigned items_done = 0;
  int unsigned mismatches = 0;
  int unsigned cycle_count = 0;
  stall_mode_t stall_mode = ST_FLOW;
  int unsigned stall_left = 0;

  tile_req_t directed_rows [18] = '{
    '{'{OP_STEP,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF}, 1'b1, NO_ADDR},
    '{'{OP_START, 32'h1234_5678, 16'h0000, 16'h0000}, 1'b1, NO_ADDR},
    '{'{OP_STEP,  32'h0000_0000, 16'h0000, 16'h0000}, 1'b1, NO_ADDR},
    '{'{OP_START, 32'hFFFF_FFFF, 16'h0002, 16'h0000}, 1'b1, NO_ADDR},
    '{'{OP_STEP,  32'h0000_0000, 16'h0000, 16'h0000}, 1'b1,
      '{1'b1, 32'hFFFF_FFFF, 24'h0, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{'{OP_STEP,  32'h0000_0000, 16'h0000, 16'h0000}, 1'b1,
      '{1'b1, 32'hFFFF_FFFF, 24'h0, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{'{OP_STEP,  32'h0000_0000, 16'h0000, 16'h0000}, 1'b1, NO_ADDR},
    '{'{OP_START, 32'h0000_0000, 16'hFFFF, 16'hFFFF}, 1'b1, NO_ADDR},
    '{'{OP_STEP,  32'h0000_0000, 16'h0000, 16'h0000}, 1'b1,
      '{1'b1, 32'h0000_0000, 24'h0, 1'b0, 1'b0, 1'b1, 1'b0}},
    '{'{OP_STEP,  32'h0000_0000, 16'h0000, 16'h0000}, 1'b0, NO_ADDR},
    '{'{OP_START, 32'hA5A5_A5A5, 16'h0001, 16'h8000}, 1'b1, NO_ADDR},
    '{'{OP_STEP,  32'h0000_0000, 16'h0000, 16'h0000}, 1'b1,
      '{1'b1, 32'hA5A5_A5A5, 24'h0, 1'b0, 1'b0, 1'b1, 1'b1}},
    '{'{OP_STEP,  32'h5A5A_5A5A, 16'h5A5A, 16'h5A5A}, 1'b1, NO_ADDR},
    '{'{OP_START, 32'h0000_0001, 16'h0003, 16'h7FFF}, 1'b1, NO_ADDR},
    '{'{OP_STEP,  32'h0000_0000, 16'h0000, 16'h0000}, 1'b0, NO_ADDR},
    '{'{OP_STEP,  32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF}, 1'b0, NO_ADDR},
    '{'{OP_STEP,  32'h0000_0000, 16'h0000, 16'h0000}, 1'b0, NO_ADDR},
    '{'{OP_STEP,  32'h0000_0000, 16'h0000, 16'h0000}, 1'b0, NO_ADDR}
  };

  function automatic int unsigned sat_dim(logic [6:0] v);
    if (v == 0) return 1;
    if (v > 64) return 64;
    return v;
  endfunction

  function automatic logic [31:0] draw_stride();
    case ($urandom_range(0, 3))
      0: return 32'd0;
      1: return 32'd1;
      default: return $urandom;
    endcase
  endfunction

  function automatic tile_addr_t next_tile_addr(entry_t c);
    tile_addr_t  r;
    int unsigned cols, rows, kcnt;
    logic        at_col, at_row, at_k, at_batch;
    r = '0;
    if (c.op == OP_START) begin
      batch_base  = c.start_tile;
      block_base  = c.start_tile;
      row_base    = c.start_tile;
      tile_cur    = c.start_tile;
      batches_rem = c.batches;
      m_idx       = c.first_m;
      k_idx       = '0;
      row_idx     = '0;
      col_idx     = '0;
      slot_off    = '0;
      walk_active = (c.batches != 0);
      return r;
    end
    if (!walk_active) return r;
    cols = sat_dim(cols_reg);
    rows = sat_dim(rows_reg);
    kcnt = (kblk_total == 0) ? 1 : kblk_total;
    at_col   = col_idx >= cols - 1;
    at_row   = row_idx >= rows - 1;
    at_k     = k_idx >= kcnt - 1;
    at_batch = batches_rem <= 1;
    r.valid_res     = 1'b1;
    r.tile_id       = tile_cur;
    r.buffer_offset = slot_off;
    r.pad_columns   = PAD_COL_EN && at_k && at_col;
    r.pad_rows      = PAD_ROW_EN && at_k && at_col;
    r.block_end     = at_row && at_col;
    r.job_end       = at_row && at_col && at_k && at_batch;
    slot_off = slot_off + SLOT_BYTES;
    tile_cur = tile_cur + COL_STEP;
    if (!at_col) begin
      col_idx = col_idx + 6'd1;
      return r;
    end
    col_idx  = '0;
    row_base = row_base + row_step;
    tile_cur = row_base;
    if (!at_row) begin
      row_idx = row_idx + 6'd1;
      return r;
    end
    row_idx    = '0;
    slot_off   = '0;
    block_base = block_base + kblk_step;
    row_base   = block_base;
    tile_cur   = block_base;
    if (!at_k) begin
      k_idx = k_idx + 16'd1;
      return r;
    end
    k_idx = '0;
    m_idx = m_idx + 16'd1;
    if (m_idx == m_per_batch) begin
      m_idx      = '0;
      batch_base = batch_base + batch_jump;
    end else begin
      batch_base = batch_base + m_step;
    end
    block_base  = batch_base;
    row_base    = batch_base;
    tile_cur    = batch_base;
    batches_rem = batches_rem - 16'd1;
    if (batches_rem == 0) walk_active = 1'b0;
    return r;
  endfunction

  task automatic send_items();
    tile_req_t   x;
    tile_addr_t  r;
    int unsigned gap;
    while (send_list.size() != 0) begin
      x = send_list.pop_front();
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      burst_left--;
      in_valid           <= 1'b1;
      command            <= x.cmd.op;
      start_tile         <= x.cmd.start_tile;
      output_block_count <= x.cmd.batches;
      first_m_block      <= x.cmd.first_m;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      r = next_tile_addr(x.cmd);
      if (r.valid_res || x.cmd.op == OP_START) items_done++;
      tile_addrs_due.insert(tile_addrs_due.size(), x.typed_in ? x.want : r);
    end
    in_valid <= 1'b0;
  endtask

  task automatic load_regs();
    cfg_reg_t idx;
    for (int i = 0; i < 8; i++) begin
      idx = cfg_reg_t'(i);
      cfg_valid <= 1'b1;
      cfg_index <= idx;
      cfg_data  <= reg_plan[idx];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      case (idx)
        REG_ROW_STRIDE:      row_step    = reg_plan[idx];
        REG_K_BLOCK_STRIDE:  kblk_step   = reg_plan[idx];
        REG_BLOCK_COLS:      cols_reg    = reg_plan[idx][6:0];
        REG_BLOCK_ROWS:      rows_reg    = reg_plan[idx][6:0];
        REG_K_BLOCK_COUNT:   kblk_total  = reg_plan[idx][15:0];
        REG_M_BLOCKS:        m_per_batch = reg_plan[idx][15:0];
        REG_M_BLOCK_STRIDE:  m_step      = reg_plan[idx];
        REG_NEXT_BATCH_JUMP: batch_jump  = reg_plan[idx];
        default: ;
      endcase
    end
    cfg_valid <= 1'b0;
  endtask

  task automatic plan_phase(phase_t ph);
    tile_req_t   x;
    int unsigned cols, rows, kcnt, jobs, steps, m;
    longint      len;
    logic [15:0] batches, first_m;
    case (ph)
      PH_WIDE: begin
        reg_plan[REG_ROW_STRIDE]      = 32'hFFFF_FFFF;
        reg_plan[REG_K_BLOCK_STRIDE]  = 32'hFFFF_FFFF;
        reg_plan[REG_BLOCK_COLS]      = 32'd64;
        reg_plan[REG_BLOCK_ROWS]      = 32'd2;
        reg_plan[REG_K_BLOCK_COUNT]   = 32'd1;
        reg_plan[REG_M_BLOCKS]        = 32'd1;
        reg_plan[REG_M_BLOCK_STRIDE]  = 32'hFFFF_FFFF;
        reg_plan[REG_NEXT_BATCH_JUMP] = 32'hFFFF_FFFF;
      end
      PH_SATURATED: begin
        reg_plan[REG_ROW_STRIDE]      = 32'd0;
        reg_plan[REG_K_BLOCK_STRIDE]  = 32'd0;
        reg_plan[REG_BLOCK_COLS]      = 32'd127;
        reg_plan[REG_BLOCK_ROWS]      = 32'd0;
        reg_plan[REG_K_BLOCK_COUNT]   = 32'd0;
        reg_plan[REG_M_BLOCKS]        = 32'd0;
        reg_plan[REG_M_BLOCK_STRIDE]  = 32'd0;
        reg_plan[REG_NEXT_BATCH_JUMP] = 32'h8000_0000;
      end
      PH_TALL_DEEP: begin
        reg_plan[REG_ROW_STRIDE]      = draw_stride();
        reg_plan[REG_K_BLOCK_STRIDE]  = draw_stride();
        reg_plan[REG_BLOCK_COLS]      = 32'd1;
        reg_plan[REG_BLOCK_ROWS]      = 32'd64;
        reg_plan[REG_K_BLOCK_COUNT]   = 32'd65535;
        reg_plan[REG_M_BLOCKS]        = 32'd65535;
        reg_plan[REG_M_BLOCK_STRIDE]  = draw_stride();
        reg_plan[REG_NEXT_BATCH_JUMP] = draw_stride();
      end
      PH_ROWS_CLAMP: begin
        reg_plan[REG_ROW_STRIDE]      = $urandom;
        reg_plan[REG_K_BLOCK_STRIDE]  = $urandom;
        reg_plan[REG_BLOCK_COLS]      = 32'd0;
        reg_plan[REG_BLOCK_ROWS]      = 32'd127;
        reg_plan[REG_K_BLOCK_COUNT]   = 32'd2;
        reg_plan[REG_M_BLOCKS]        = 32'd2;
        reg_plan[REG_M_BLOCK_STRIDE]  = $urandom;
        reg_plan[REG_NEXT_BATCH_JUMP] = $urandom;
      end
      default: begin
        reg_plan[REG_ROW_STRIDE]      = draw_stride();
        reg_plan[REG_K_BLOCK_STRIDE]  = draw_stride();
        reg_plan[REG_BLOCK_COLS]      = $urandom_range(1, 5);
        reg_plan[REG_BLOCK_ROWS]      = $urandom_range(1, 4);
        reg_plan[REG_K_BLOCK_COUNT]   = $urandom_range(1, 3);
        reg_plan[REG_M_BLOCKS]        = $urandom_range(1, 4);
        reg_plan[REG_M_BLOCK_STRIDE]  = draw_stride();
        reg_plan[REG_NEXT_BATCH_JUMP] = draw_stride();
      end
    endcase
    cols = sat_dim(reg_plan[REG_BLOCK_COLS][6:0]);
    rows = sat_dim(reg_plan[REG_BLOCK_ROWS][6:0]);
    kcnt = (reg_plan[REG_K_BLOCK_COUNT][15:0] == 0) ? 1 : reg_plan[REG_K_BLOCK_COUNT][15:0];
    m    = reg_plan[REG_M_BLOCKS][15:0];
    jobs = $urandom_range(1, 4);
    repeat (jobs) begin
      x = '0;
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          x.cmd.op         = op_t'($urandom_range(0, 1));
          x.cmd.start_tile = $urandom;
          x.cmd.batches    = 16'($urandom);
          x.cmd.first_m    = 16'($urandom);
          send_list.insert(send_list.size(), x);
        end
      end
      case ($urandom_range(0, 15))
        0: batches = 16'd0;
        1: batches = 16'($urandom_range(4, 65535));
        default: batches = 16'($urandom_range(1, 3));
      endcase
      case ($urandom_range(0, 2))
        0: first_m = 16'd0;
        1: first_m = (m == 0) ? 16'hFFFF : 16'($urandom_range(0, m - 1));
        default: first_m = 16'($urandom);
      endcase
      x.cmd.op         = OP_START;
      x.cmd.start_tile = $urandom;
      x.cmd.batches    = batches;
      x.cmd.first_m    = first_m;
      send_list.insert(send_list.size(), x);
      len = longint'(cols) * rows * kcnt * batches;
      if (len > JOB_CAP) len = JOB_CAP;
      if (len > 1 && $urandom_range(0, 5) == 0) steps = $urandom_range(1, int'(len) - 1);
      else steps = int'(len) + $urandom_range(0, 2);
      repeat (steps) begin
        x.cmd.op         = OP_STEP;
        x.cmd.start_tile = $urandom;
        x.cmd.batches    = 16'($urandom);
        x.cmd.first_m    = 16'($urandom);
        send_list.insert(send_list.size(), x);
      end
    end
  endtask

  always @(posedge clk) begin
    if (stall_left == 0) begin
      stall_mode <= stall_mode_t'($urandom_range(0, 3));
      stall_left <= $urandom_range(16, 160);
    end else begin
      stall_left <= stall_left - 1;
    end
    case (stall_mode)
      ST_FLOW:  out_stall <= 1'b0;
      ST_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
      ST_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
      default:  out_stall <= ((cycle_count % 5) < 2);
    endcase
  end

  always @(posedge clk) begin : check_results
    tile_addr_t want;
    if (!rst && out_valid && !out_stall) begin
      if (tile_addrs_due.size() == 0) begin
        $error("result with nothing expected: tile_id %h", tile_id);
        mismatches++;
      end else begin
        want = tile_addrs_due.pop_front();
        if (valid_res !== want.valid_res) begin
          $error("valid_res: expected %0h, got %0h", want.valid_res, valid_res);
          mismatches++;
        end
        if (tile_id !== want.tile_id) begin
          $error("tile_id: expected %h, got %h", want.tile_id, tile_id);
          mismatches++;
        end
        if (buffer_offset !== want.buffer_offset) begin
          $error("buffer_offset: expected %h, got %h", want.buffer_offset, buffer_offset);
          mismatches++;
        end
        if (pad_columns !== want.pad_columns) begin
          $error("pad_columns: expected %0h, got %0h", want.pad_columns, pad_columns);
          mismatches++;
        end
        if (pad_rows !== want.pad_rows) begin
          $error("pad_rows: expected %0h, got %0h", want.pad_rows, pad_rows);
          mismatches++;
        end
        if (block_end !== want.block_end) begin
          $error("block_end: expected %0h, got %0h", want.block_end, block_end);
          mismatches++;
        end
        if (job_end !== want.job_end) begin
          $error("job_end: expected %0h, got %0h", want.job_end, job_end);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin : run
    int unsigned phase;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    foreach (directed_rows[i]) send_list.insert(send_list.size(), directed_rows[i]);
    send_items();
    phase = 0;
    while (items_done < TARGET_ITEMS) begin
      while (tile_addrs_due.size() != 0) @(posedge clk);
      plan_phase((phase < PH_RANDOM) ? phase_t'(phase) : PH_RANDOM);
      load_regs();
      send_items();
      phase++;
    end
    while (tile_addrs_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
